/* design/glob_wildcard_matcher_unit_macros.svh */
// Assertion macros shared by the glob matcher RTL.
`ifndef GLOB_WILDCARD_MATCHER_UNIT_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger.
`define GWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("glob matcher check failed");
// Check a condition in the cycle after its trigger.
`define GWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("glob matcher check failed");
`else
`define GWM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/gwm_pkg.sv */
package gwm_pkg;

    localparam int CH_W          = 8;
    localparam int TOTAL_W       = 24;
    localparam int PATTERN_MAX_D = 32;
    localparam int COUNT_BITS_D  = 24;

    // Pattern metacharacters
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CH_W-1:0] CH_DASH   = 8'h2D;

    // Item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    // Control from the top level to the token parser
    typedef struct packed {
        logic clear;
        logic start;
    } t_parse_ctrl;

endpackage

/* design/glob_wildcard_matcher_unit.sv */
// Glob matcher. Pattern words (func 0) are stored one per cycle. The last
// pattern word starts the parser, which then walks the pattern once. No
// word is accepted while it walks. Text words (func 1) are then taken one
// per cycle, but the last word of a line waits while an unread result
// word is held at the output. Each one updates the active position set
// through one stage of logic between the input register and the result
// register. The last word of a line gives one result word with the match
// flag, the saturating match count and the overflow flag.
`include "glob_wildcard_matcher_unit_macros.svh"
module glob_wildcard_matcher_unit #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_D,
    parameter int COUNT_BITS  = gwm_pkg::COUNT_BITS_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [gwm_pkg::CH_W-1:0]    i_ch,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_matched,
    output logic [gwm_pkg::TOTAL_W-1:0] o_match_total,
    output logic                        o_pattern_error
);
    import gwm_pkg::*;

    localparam int PW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);

    logic [PATTERN_MAX-1:0][CH_W-1:0] r_store;
    logic [PW-1:0]          r_len;
    logic                   r_closed;
    logic                   r_ovf;
    logic [PATTERN_MAX:0]   r_active;
    logic [COUNT_BITS-1:0]  r_count;

    logic                   r_in_v, r_in_func, r_in_last;
    logic [CH_W-1:0]        r_in_ch;
    logic                   r_out_v, r_out_matched, r_out_err;
    logic [TOTAL_W-1:0]     r_out_total;

    t_parse_ctrl            w_ctrl;
    logic                   w_busy;
    logic [PATTERN_MAX-1:0] w_start, w_neg, w_lit, w_rng;
    logic [PATTERN_MAX-1:0][PW-1:0] w_next;

    logic                   w_produce, w_fire;
    logic [PATTERN_MAX-1:0] w_tok_ok, w_star, w_elem_hit, w_pass;
    logic [PATTERN_MAX:0]   w_cur, w_step, w_nxt;
    logic                   w_hit;
    logic [COUNT_BITS-1:0]  w_count_new;
    logic [COUNT_BITS+TOTAL_W-1:0] w_count_ext;
    logic [PW-1:0]          w_len_eff;
    logic                   w_ovf_eff;
    logic [CH_W-1:0]        w_lo, w_hi, w_e, w_b;

    // Handshake
    assign w_produce = r_in_func == FUNC_TEXT && r_in_last && r_closed;
    assign w_fire    = r_in_v && !w_busy && !(w_produce && r_out_v && !i_ready);
    assign o_ready   = !w_busy && !(r_in_v && r_in_func == FUNC_LOAD && r_in_last) &&
                       (!r_in_v || w_fire);

    assign w_ctrl.clear = w_fire && r_in_func == FUNC_LOAD && r_closed;
    assign w_ctrl.start = w_fire && r_in_func == FUNC_LOAD && r_in_last;

    gwm_parse #(
        .PATTERN_MAX (PATTERN_MAX),
        .PW          (PW),
        .IW          (IW)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_store (r_store),
        .i_len   (r_len),
        .o_busy  (w_busy),
        .o_start (w_start),
        .o_neg   (w_neg),
        .o_lit   (w_lit),
        .o_rng   (w_rng),
        .o_next  (w_next)
    );

    // Per-position token and set member matches
    always_comb begin
        for (int p = 0; p < PATTERN_MAX; p++) begin
            w_tok_ok[p] = w_start[p] && (PW'(p) < r_len);
            w_star[p]   = w_tok_ok[p] && r_store[p] == CH_STAR;
            w_e         = r_store[p];
            w_b         = (p + 2 < PATTERN_MAX) ? r_store[(p + 2) % PATTERN_MAX] : '0;
            w_lo        = (w_e < w_b) ? w_e : w_b;
            w_hi        = (w_e < w_b) ? w_b : w_e;
            w_elem_hit[p] = (w_lit[p] && w_e == r_in_ch) ||
                            (w_rng[p] && r_in_ch >= w_lo && r_in_ch <= w_hi);
        end
        for (int p = 0; p < PATTERN_MAX; p++) begin
            logic found;
            found = 1'b0;
            for (int q = p + 1; q < PATTERN_MAX; q++) begin
                if (PW'(q) < w_next[p] && w_elem_hit[q]) begin
                    found = 1'b1;
                end
            end
            if (r_store[p] == CH_QMARK) begin
                w_pass[p] = 1'b1;
            end else if (r_store[p] == CH_LBRACK) begin
                w_pass[p] = found ^ w_neg[p];
            end else begin
                w_pass[p] = r_store[p] == r_in_ch;
            end
        end
    end

    // Advance the active set: close over stars, step, close again
    always_comb begin
        w_cur = r_active;
        for (int p = 0; p < PATTERN_MAX; p++) begin
            w_cur[p + 1] = w_cur[p + 1] | (w_cur[p] & w_star[p]);
        end
        w_step = '0;
        for (int p = 0; p < PATTERN_MAX; p++) begin
            if (w_cur[p] && w_tok_ok[p]) begin
                if (w_star[p]) begin
                    w_step[p] = 1'b1;
                end else if (w_pass[p]) begin
                    w_step[w_next[p]] = 1'b1;
                end
            end
        end
        w_nxt = w_step;
        for (int p = 0; p < PATTERN_MAX; p++) begin
            w_nxt[p + 1] = w_nxt[p + 1] | (w_nxt[p] & w_star[p]);
        end
    end

    assign w_hit       = !r_ovf && w_nxt[r_len];
    assign w_count_new = (w_hit && r_count != '1) ? r_count + COUNT_BITS'(1) : r_count;
    assign w_count_ext = {{TOTAL_W{1'b0}}, w_count_new};
    assign w_len_eff   = r_closed ? '0 : r_len;
    assign w_ovf_eff   = r_closed ? 1'b0 : r_ovf;

    // Hold input word, pattern state and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_len    <= '0;
            r_closed <= 1'b1;
            r_ovf    <= 1'b0;
            r_active <= (PATTERN_MAX+1)'(1);
            r_count  <= '0;
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end else if (w_fire) begin
                r_in_v <= 1'b0;
            end
            if (w_fire && w_produce) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (w_fire) begin
                if (r_in_func == FUNC_LOAD) begin
                    if (r_closed) begin
                        r_count <= '0;
                    end
                    r_closed <= r_in_last;
                    if (w_len_eff < PW'(PATTERN_MAX)) begin
                        r_len <= w_len_eff + PW'(1);
                        r_ovf <= w_ovf_eff;
                    end else begin
                        r_len <= w_len_eff;
                        r_ovf <= 1'b1;
                    end
                    if (r_in_last) begin
                        r_active <= (PATTERN_MAX+1)'(1);
                    end
                end else if (r_closed) begin
                    if (r_in_last) begin
                        r_active <= (PATTERN_MAX+1)'(1);
                        r_count  <= w_count_new;
                    end else begin
                        r_active <= w_nxt;
                    end
                end
            end
        end
        if (o_ready && i_valid) begin
            r_in_func <= i_func;
            r_in_ch   <= i_ch;
            r_in_last <= i_last;
        end
        if (w_fire && r_in_func == FUNC_LOAD && w_len_eff < PW'(PATTERN_MAX)) begin
            r_store[w_len_eff[IW-1:0]] <= r_in_ch;
        end
        if (w_fire && w_produce) begin
            r_out_matched <= w_hit;
            r_out_total   <= w_count_ext[TOTAL_W-1:0];
            r_out_err     <= r_ovf;
        end
    end

    assign o_valid         = r_out_v;
    assign o_matched       = r_out_matched;
    assign o_match_total   = r_out_total;
    assign o_pattern_error = r_out_err;

    `GWM_ASSERT_NOW(a_busy_blocks_input, i_clk, i_rst_n, w_busy, !o_ready)
    `GWM_ASSERT_NOW(a_error_never_matches, i_clk, i_rst_n, r_out_v && r_out_err, !r_out_matched)
    `GWM_ASSERT_NEXT(a_count_never_drops, i_clk, i_rst_n, w_fire && r_in_func == FUNC_TEXT, r_count >= $past(r_count))

endmodule

/* design/gwm_parse.sv */
// Token parser: walks the loaded pattern once, a byte or a whole set range at a time, and builds
// the token start map, token end positions and set member flags.
module gwm_parse #(
    parameter int PATTERN_MAX = 32,
    parameter int PW          = 6,
    parameter int IW          = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gwm_pkg::t_parse_ctrl         i_ctrl,
    input  logic [PATTERN_MAX-1:0][7:0]  i_store,
    input  logic [PW-1:0]                i_len,
    output logic                         o_busy,
    output logic [PATTERN_MAX-1:0]       o_start,
    output logic [PATTERN_MAX-1:0]       o_neg,
    output logic [PATTERN_MAX-1:0]       o_lit,
    output logic [PATTERN_MAX-1:0]       o_rng,
    output logic [PATTERN_MAX-1:0][PW-1:0] o_next
);
    import gwm_pkg::*;

    logic                          r_busy, n_busy;
    logic [PW-1:0]                 r_q, n_q;
    logic                          r_in_set, n_in_set;
    logic [IW-1:0]                 r_tok, n_tok;
    logic [PATTERN_MAX-1:0]        r_start, n_start;
    logic [PATTERN_MAX-1:0]        r_neg, n_neg;
    logic [PATTERN_MAX-1:0]        r_lit, n_lit;
    logic [PATTERN_MAX-1:0]        r_rng, n_rng;
    logic [PATTERN_MAX-1:0][PW-1:0] r_next, n_next;

    logic [IW-1:0] w_qi, w_q1i, w_q2i;
    logic [PW:0]   w_q1w, w_q2w;
    logic [PW-1:0] w_q1, w_q3;
    logic          w_q1_ok, w_q2_ok;

    // Lookahead positions
    assign w_qi    = r_q[IW-1:0];
    assign w_q1w   = {1'b0, r_q} + (PW+1)'(1);
    assign w_q2w   = {1'b0, r_q} + (PW+1)'(2);
    assign w_q1    = w_q1w[PW-1:0];
    assign w_q3    = r_q + PW'(3);
    assign w_q1i   = w_q1w[IW-1:0];
    assign w_q2i   = w_q2w[IW-1:0];
    assign w_q1_ok = w_q1w < {1'b0, i_len};
    assign w_q2_ok = w_q2w < {1'b0, i_len};

    // Advance the walk by one pattern byte, or by a whole set range
    always_comb begin
        n_busy   = r_busy;
        n_q      = r_q;
        n_in_set = r_in_set;
        n_tok    = r_tok;
        n_start  = r_start;
        n_neg    = r_neg;
        n_lit    = r_lit;
        n_rng    = r_rng;
        n_next   = r_next;
        if (i_ctrl.clear) begin
            n_start = '0;
            n_neg   = '0;
            n_lit   = '0;
            n_rng   = '0;
        end
        if (i_ctrl.start) begin
            n_busy   = 1'b1;
            n_q      = '0;
            n_in_set = 1'b0;
        end else if (r_busy) begin
            if (r_q >= i_len) begin
                if (r_in_set) begin
                    n_next[r_tok] = i_len;
                end
                n_busy   = 1'b0;
                n_in_set = 1'b0;
            end else if (!r_in_set) begin
                n_start[w_qi] = 1'b1;
                n_q           = w_q1;
                if (i_store[w_qi] == CH_LBRACK) begin
                    n_tok    = w_qi;
                    n_in_set = 1'b1;
                    if (w_q1_ok && (i_store[w_q1i] == CH_CARET ||
                                    i_store[w_q1i] == CH_BANG)) begin
                        n_neg[w_qi] = 1'b1;
                    end
                end else begin
                    n_next[w_qi] = w_q1;
                end
            end else begin
                if (i_store[w_qi] == CH_RBRACK) begin
                    n_next[r_tok] = w_q1;
                    n_in_set      = 1'b0;
                    n_q           = w_q1;
                end else if (w_q2_ok && i_store[w_q1i] == CH_DASH &&
                             i_store[w_q2i] != CH_RBRACK) begin
                    n_rng[w_qi] = 1'b1;
                    n_q         = w_q3;
                end else begin
                    n_lit[w_qi] = 1'b1;
                    n_q         = w_q1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_q      <= '0;
            r_in_set <= 1'b0;
            r_tok    <= '0;
            r_start  <= '0;
            r_neg    <= '0;
            r_lit    <= '0;
            r_rng    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_q      <= n_q;
            r_in_set <= n_in_set;
            r_tok    <= n_tok;
            r_start  <= n_start;
            r_neg    <= n_neg;
            r_lit    <= n_lit;
            r_rng    <= n_rng;
        end
        r_next <= n_next;
    end

    assign o_busy  = r_busy;
    assign o_start = r_start;
    assign o_neg   = r_neg;
    assign o_lit   = r_lit;
    assign o_rng   = r_rng;
    assign o_next  = r_next;

endmodule
